// File: rtl/vfs_pkg.sv
// shared types, constants and codes for the voxel face shader
package vfs_pkg;

    localparam int ChanW      = 12;          // 7*255 + 3*255 fits in 12 bits
    localparam int QDepth     = 2;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);
    localparam int RecipW     = 13;
    localparam int RecipShift = 16;
    localparam logic [RecipW-1:0] RecipTen = 13'd6554;   // ceil(2^16 / 10)
    localparam int ProdW      = ChanW + RecipW;

    localparam logic [7:0]  RedMin        = 8'd200;
    localparam logic [7:0]  OtherMax      = 8'd100;
    localparam logic [23:0] InteriorColor = 24'hFF0000;

    localparam logic [23:0] TopReset    = 24'hFFFF00;
    localparam logic [23:0] BottomReset = 24'h0000FF;
    localparam logic [23:0] FrontReset  = 24'h00FFFF;
    localparam logic [23:0] BackReset   = 24'hFF0000;
    localparam logic [23:0] LeftReset   = 24'hFF00FF;
    localparam logic [23:0] RightReset  = 24'h00FF00;

    localparam int CfgIdxW = 3;

    typedef enum logic [2:0] {
        FACE_TOP      = 3'd0,
        FACE_BOTTOM   = 3'd1,
        FACE_FRONT    = 3'd2,
        FACE_BACK     = 3'd3,
        FACE_LEFT     = 3'd4,
        FACE_RIGHT    = 3'd5,
        FACE_INTERIOR = 3'd6
    } t_face;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TOP_COLOR    = 3'd0,
        REG_BOTTOM_COLOR = 3'd1,
        REG_FRONT_COLOR  = 3'd2,
        REG_BACK_COLOR   = 3'd3,
        REG_LEFT_COLOR   = 3'd4,
        REG_RIGHT_COLOR  = 3'd5,
        REG_BLEND_MODE   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_REPLACE = 2'd0,
        MODE_BLEND   = 2'd1,
        MODE_RED_LO  = 2'd2,
        MODE_RED_HI  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [5:0][23:0] palette;   // indexed by face code
        t_mode            mode;
    } t_cfg;

    // one classified voxel on its way to the back end
    typedef struct packed {
        logic                  status;
        t_face                 face;
        logic [7:0]            alpha;
        logic                  blend;   // chan holds 7*face + 3*base, still to divide by 10
        logic [2:0][ChanW-1:0] chan;    // red, green, blue from high to low
    } t_entry;

endpackage

// File: rtl/vfs_if.sv
// channel interfaces: voxel input, shaded result output, register writes
interface vfs_in_if;
    import vfs_pkg::*;
    logic       valid;
    logic       ready;
    logic       voxel_present;
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] base_alpha;
    logic [5:0] exposed_faces;

    modport source (output valid, voxel_present, base_red, base_green, base_blue,
                    base_alpha, exposed_faces, input ready);
    modport sink   (input valid, voxel_present, base_red, base_green, base_blue,
                    base_alpha, exposed_faces, output ready);
endinterface

interface vfs_out_if;
    import vfs_pkg::*;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [2:0] chosen_face;

    modport source (output valid, status, out_red, out_green, out_blue, out_alpha,
                    chosen_face, input ready);
    modport sink   (input valid, status, out_red, out_green, out_blue, out_alpha,
                    chosen_face, output ready);
endinterface

interface vfs_cfg_if;
    import vfs_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [23:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/vfs_front.sv
// front end: accepts voxels, picks the face and prepares the channel values
module vfs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vfs_in_if.sink          i_in,
    input  vfs_pkg::t_cfg   i_cfg,
    output logic            o_push_valid,
    output vfs_pkg::t_entry o_push_entry,
    input  logic            i_push_ready
);
    import vfs_pkg::*;

    logic        r_valid;
    t_entry      r_entry;
    t_entry      n_entry;
    t_face       face;
    logic [23:0] color;
    logic [5:0]  f;
    logic        ax, ay, az;
    logic        red_voxel;
    logic [2:0][7:0] face_ch;
    logic [2:0][7:0] base_ch;
    logic        take;

    assign i_in.ready = !r_valid || i_push_ready;
    assign take       = i_in.valid && i_in.ready;

    assign f  = i_in.exposed_faces;
    assign ay = f[0] ^ f[1];
    assign ax = f[3] ^ f[2];
    assign az = f[4] ^ f[5];

    always_comb begin
        if (f == 6'd0) begin
            face = FACE_INTERIOR;
        end else if (ay && !ax && !az) begin
            face = f[0] ? FACE_TOP : FACE_BOTTOM;
        end else if (ax && !az) begin
            face = f[3] ? FACE_RIGHT : FACE_LEFT;
        end else begin
            // cancelled normals land here too and give back
            face = (f[4] && !f[5]) ? FACE_FRONT : FACE_BACK;
        end
    end

    assign color   = (face == FACE_INTERIOR) ? InteriorColor : i_cfg.palette[face];
    assign face_ch = color;
    assign base_ch = {i_in.base_red, i_in.base_green, i_in.base_blue};
    assign red_voxel = (i_in.base_red > RedMin) && (i_in.base_green < OtherMax)
                    && (i_in.base_blue < OtherMax);

    always_comb begin
        n_entry        = '0;
        n_entry.status = !i_in.voxel_present;
        if (i_in.voxel_present) begin
            n_entry.face  = face;
            n_entry.alpha = i_in.base_alpha;
            for (int c = 0; c < 3; c++) begin
                case (i_cfg.mode)
                    MODE_REPLACE: begin
                        n_entry.chan[c] = ChanW'(face_ch[c]);
                    end
                    MODE_BLEND: begin
                        n_entry.chan[c] = (ChanW'({face_ch[c], 3'b000}) - ChanW'(face_ch[c]))
                                        + (ChanW'({base_ch[c], 1'b0}) + ChanW'(base_ch[c]));
                    end
                    default: begin
                        n_entry.chan[c] = red_voxel ? ChanW'(face_ch[c])
                                                    : ChanW'(base_ch[c]);
                    end
                endcase
            end
            n_entry.blend = (i_cfg.mode == MODE_BLEND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry <= n_entry;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_entry = r_entry;

endmodule

// File: rtl/vfs_queue.sv
// short queue between the front and back ends
module vfs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  vfs_pkg::t_entry i_push_entry,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output vfs_pkg::t_entry o_pop_entry,
    input  logic            i_pop_ready
);
    import vfs_pkg::*;

    t_entry           r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != QCntW'(QDepth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// File: rtl/vfs_back.sv
// back end: divides blended channels by ten and holds the result for the sink
module vfs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    input  vfs_pkg::t_entry i_pop_entry,
    output logic            o_pop_ready,
    vfs_out_if.source       o_out
);
    import vfs_pkg::*;

    logic              r_valid;
    logic              r_status;
    logic [2:0]        r_face;
    logic [7:0]        r_alpha;
    logic [2:0][7:0]   r_rgb;
    logic [2:0][7:0]   n_rgb;
    logic [ProdW-1:0]  prod [3];
    logic              load;

    assign o_pop_ready = !r_valid || o_out.ready;
    assign load        = i_pop_valid && o_pop_ready;

    // floor(x / 10) as (x * 6554) >> 16, exact for the 12-bit sums here
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c]  = ProdW'(i_pop_entry.chan[c]) * ProdW'(RecipTen);
            n_rgb[c] = i_pop_entry.blend ? prod[c][RecipShift +: 8]
                                         : i_pop_entry.chan[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_pop_entry.status;
            r_face   <= i_pop_entry.face;
            r_alpha  <= i_pop_entry.alpha;
            r_rgb    <= n_rgb;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.out_red     = r_rgb[2];
    assign o_out.out_green   = r_rgb[1];
    assign o_out.out_blue    = r_rgb[0];
    assign o_out.out_alpha   = r_alpha;
    assign o_out.chosen_face = r_face;

endmodule

// File: rtl/voxel_face_shade.sv
// voxel face shader top level: register file, front end, queue, back end
//
//  channel   dir   payload                                            transaction
//  i_in      in    voxel_present, base_red/green/blue/alpha, faces    valid & ready
//  o_out     out   status, out_red/green/blue/alpha, chosen_face      valid & ready
//  i_cfg     in    index (3 bits), data (24 bits)                     valid & ready
//
//  one voxel per cycle sustained while o_out.ready stays high; a result is registered in
//  each stage in turn and leaves at the first edge with o_out.ready high
//  (front register, 2-entry queue, back output register with the divide-by-ten multiply)
//  synchronous active-low reset clears control state and loads the register reset values
//  front and back stall independently; the queue absorbs a short output stall
//  i_cfg.ready is always high; writes to an index past the blend mode are dropped
module voxel_face_shade (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfs_in_if.sink    i_in,
    vfs_out_if.source o_out,
    vfs_cfg_if.sink   i_cfg
);
    import vfs_pkg::*;

    t_cfg   r_cfg;
    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.palette[FACE_TOP]    <= TopReset;
            r_cfg.palette[FACE_BOTTOM] <= BottomReset;
            r_cfg.palette[FACE_FRONT]  <= FrontReset;
            r_cfg.palette[FACE_BACK]   <= BackReset;
            r_cfg.palette[FACE_LEFT]   <= LeftReset;
            r_cfg.palette[FACE_RIGHT]  <= RightReset;
            r_cfg.mode                 <= MODE_REPLACE;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_TOP_COLOR:    r_cfg.palette[FACE_TOP]    <= i_cfg.data;
                REG_BOTTOM_COLOR: r_cfg.palette[FACE_BOTTOM] <= i_cfg.data;
                REG_FRONT_COLOR:  r_cfg.palette[FACE_FRONT]  <= i_cfg.data;
                REG_BACK_COLOR:   r_cfg.palette[FACE_BACK]   <= i_cfg.data;
                REG_LEFT_COLOR:   r_cfg.palette[FACE_LEFT]   <= i_cfg.data;
                REG_RIGHT_COLOR:  r_cfg.palette[FACE_RIGHT]  <= i_cfg.data;
                REG_BLEND_MODE:   r_cfg.mode <= t_mode'(i_cfg.data[1:0]);
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    vfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    vfs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    vfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    // nothing comes out in the cycle after reset
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // a blocked front entry waits unchanged for the queue
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid && !push_ready |=> push_valid && $stable(push_entry))
        else $error("front entry dropped or changed while queue full");

    // absent voxels carry zero colors and face code zero
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |-> o_out.out_red == 8'd0 && o_out.out_green == 8'd0
            && o_out.out_blue == 8'd0 && o_out.out_alpha == 8'd0
            && o_out.chosen_face == FACE_TOP)
        else $error("absent voxel result not cleared");

    // a queued blended entry always holds a sum below 2560
    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_valid && pop_entry.blend |-> pop_entry.chan[0] < 12'd2560
            && pop_entry.chan[1] < 12'd2560 && pop_entry.chan[2] < 12'd2560)
        else $error("blend sum out of range");
`endif

endmodule

// File: tb/voxel_face_shade_tb.sv
// self-checking testbench for the voxel face shader with a built-in shading predictor
`timescale 1ns / 100ps

module voxel_face_shade_tb;
    import vfs_pkg::*;

    localparam int CycleLimit   = 300000;
    localparam int SettleCycles = 8;      // idle margin once every expected result is back
    localparam int RandomItems  = 780;
    localparam int RandomPhases = 6;

    // exposed face bits
    localparam logic [5:0] FacePosY = 6'b000001;
    localparam logic [5:0] FaceNegY = 6'b000010;
    localparam logic [5:0] FaceNegX = 6'b000100;
    localparam logic [5:0] FacePosX = 6'b001000;
    localparam logic [5:0] FacePosZ = 6'b010000;
    localparam logic [5:0] FaceNegZ = 6'b100000;

    localparam logic [7:0]  StrongRedMin = 8'd200;
    localparam logic [7:0]  WeakChanMax  = 8'd100;
    localparam logic [23:0] InteriorRgb  = 24'hFF0000;
    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    typedef struct packed {
        logic       present;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [5:0] faces;
    } t_voxel;

    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        t_face      face;
    } t_shade;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vfs_in_if  in_ch ();
    vfs_out_if out_ch ();
    vfs_cfg_if cfg_ch ();

    voxel_face_shade u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the register file
    logic [23:0] face_rgb [6];
    t_mode       shade_mode;

    t_shade shade_expect [$];
    int     errors;
    int     cycle_cnt;

    // sender burst control
    bit src_gaps;
    int burst_left;

    // receiver control
    int          sink_style;
    logic [15:0] sink_pattern;
    int          hold_req;
    int          hold_left;

    function automatic t_shade shade_voxel(input t_voxel v);
        t_shade      s;
        int          sx, sy, sz, ax, ay, az;
        logic [23:0] rgb;
        s = '0;
        if (!v.present) begin
            s.status = 1'b1;
            s.face   = FACE_TOP;
            return s;
        end
        sy = int'(v.faces[0]) - int'(v.faces[1]);
        sx = int'(v.faces[3]) - int'(v.faces[2]);
        sz = int'(v.faces[4]) - int'(v.faces[5]);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        if (v.faces == 6'd0)
            s.face = FACE_INTERIOR;
        else if (ay > ax && ay > az)
            s.face = (sy > 0) ? FACE_TOP : FACE_BOTTOM;
        else if (ax > az)
            s.face = (sx > 0) ? FACE_RIGHT : FACE_LEFT;
        else
            s.face = (sz > 0) ? FACE_FRONT : FACE_BACK;
        rgb = (s.face == FACE_INTERIOR) ? InteriorRgb : face_rgb[s.face];
        case (shade_mode)
            MODE_REPLACE: begin
                {s.red, s.green, s.blue} = rgb;
            end
            MODE_BLEND: begin
                s.red   = 8'((7 * int'(rgb[23:16]) + 3 * int'(v.red)) / 10);
                s.green = 8'((7 * int'(rgb[15:8]) + 3 * int'(v.green)) / 10);
                s.blue  = 8'((7 * int'(rgb[7:0]) + 3 * int'(v.blue)) / 10);
            end
            default: begin
                // only strongly red material takes the face color
                if (v.red > StrongRedMin && v.green < WeakChanMax && v.blue < WeakChanMax)
                    {s.red, s.green, s.blue} = rgb;
                else
                    {s.red, s.green, s.blue} = {v.red, v.green, v.blue};
            end
        endcase
        s.alpha = v.alpha;
        return s;
    endfunction

    function automatic t_voxel mk_voxel(input logic present, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [7:0] a, input logic [5:0] faces);
        t_voxel v;
        v.present = present;
        v.red     = r;
        v.green   = g;
        v.blue    = b;
        v.alpha   = a;
        v.faces   = faces;
        return v;
    endfunction

    function automatic t_voxel random_voxel();
        t_voxel v;
        v.present = ($urandom_range(0, 9) != 0);
        v.red     = 8'($urandom);
        v.green   = 8'($urandom);
        v.blue    = 8'($urandom);
        v.alpha   = 8'($urandom);
        v.faces   = 6'($urandom);
        // land near the strong-red thresholds often
        if ($urandom_range(0, 2) == 0) begin
            v.red   = 8'($urandom_range(190, 255));
            v.green = 8'($urandom_range(0, 110));
            v.blue  = 8'($urandom_range(0, 110));
        end
        return v;
    endfunction

    function automatic logic [23:0] random_rgb();
        logic [23:0] c;
        c = 24'($urandom);
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 7))
                0: c[i*8 +: 8] = 8'h00;
                1: c[i*8 +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic send_voxel(input t_voxel v);
        int gap;
        if (src_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.voxel_present <= v.present;
        in_ch.base_red      <= v.red;
        in_ch.base_green    <= v.green;
        in_ch.base_blue     <= v.blue;
        in_ch.base_alpha    <= v.alpha;
        in_ch.exposed_faces <= v.faces;
        do @(posedge i_clk); while (!in_ch.ready);
        shade_expect.push_back(shade_voxel(v));
        if (burst_left > 0)
            burst_left--;
    endtask

    // stop offering voxels and wait until every shaded result is back
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (shade_expect.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx <= REG_RIGHT_COLOR)
            face_rgb[idx] = data;
        else if (idx == REG_BLEND_MODE)
            shade_mode = t_mode'(data[1:0]);
    endtask

    // full register load while idle, plus a stray write past the register list
    task automatic load_config(input logic [5:0][23:0] colors, input t_mode mode);
        logic [23:0] mode_word;
        drain_results();
        for (int i = 0; i <= int'(REG_RIGHT_COLOR); i++)
            write_reg(CfgIdxW'(i), colors[i]);
        mode_word      = 24'($urandom);
        mode_word[1:0] = mode;
        write_reg(REG_BLEND_MODE, mode_word);
        write_reg(RegUnused, 24'($urandom));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_face_select();
        send_voxel(mk_voxel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h3F));
        send_voxel(mk_voxel(1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 6'h00));
        send_voxel(mk_voxel(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, FacePosY));
        send_voxel(mk_voxel(1'b1, 8'h12, 8'h34, 8'h56, 8'h78, FaceNegY));
        send_voxel(mk_voxel(1'b1, 8'h12, 8'h34, 8'h56, 8'h78, FaceNegX));
        send_voxel(mk_voxel(1'b1, 8'h12, 8'h34, 8'h56, 8'h78, FacePosX));
        send_voxel(mk_voxel(1'b1, 8'h12, 8'h34, 8'h56, 8'h78, FacePosZ));
        send_voxel(mk_voxel(1'b1, 8'h12, 8'h34, 8'h56, 8'h78, FaceNegZ));
        // opposite faces cancel to a zero normal
        send_voxel(mk_voxel(1'b1, 8'h00, 8'hFF, 8'h00, 8'h01, FacePosY | FaceNegY));
        send_voxel(mk_voxel(1'b1, 8'h00, 8'hFF, 8'h00, 8'h01, 6'h3F));
        // ties: y never wins a tie, x against z goes to z
        send_voxel(mk_voxel(1'b1, 8'h80, 8'h80, 8'h80, 8'h80, FacePosY | FacePosX));
        send_voxel(mk_voxel(1'b1, 8'h80, 8'h80, 8'h80, 8'h80, FaceNegX | FacePosZ));
        send_voxel(mk_voxel(1'b1, 8'h80, 8'h80, 8'h80, 8'h80, FaceNegY | FacePosX | FaceNegZ));
    endtask

    task automatic test_config_extremes();
        load_config('0, MODE_REPLACE);
        send_voxel(mk_voxel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FacePosX));
        send_voxel(mk_voxel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h00));
        load_config({6{24'hFFFFFF}}, MODE_BLEND);
        send_voxel(mk_voxel(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, FaceNegZ));
        send_voxel(mk_voxel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FacePosY));
        send_voxel(mk_voxel(1'b1, 8'h00, 8'hFF, 8'h09, 8'h33, 6'h00));
    endtask

    task automatic test_red_material();
        load_config({24'h102030, 24'h405060, 24'h708090, 24'hA0B0C0, 24'hD0E0F0, 24'h0A0B0C},
                    MODE_RED_LO);
        send_voxel(mk_voxel(1'b1, 8'd201, 8'd99, 8'd99, 8'h44, FacePosZ));
        send_voxel(mk_voxel(1'b1, 8'd200, 8'd99, 8'd99, 8'h44, FacePosZ));
        send_voxel(mk_voxel(1'b1, 8'd201, 8'd100, 8'd99, 8'h44, FaceNegX));
        send_voxel(mk_voxel(1'b1, 8'd201, 8'd99, 8'd100, 8'h44, FaceNegY));
        load_config({24'h102030, 24'h405060, 24'h708090, 24'hA0B0C0, 24'hD0E0F0, 24'h0A0B0C},
                    MODE_RED_HI);
        send_voxel(mk_voxel(1'b1, 8'hFF, 8'h00, 8'h00, 8'hEE, 6'h00));
        send_voxel(mk_voxel(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hEE, FacePosY));
    endtask

    // hold the receiver off while the sender keeps offering, then let it all drain
    task automatic test_backpressure();
        src_gaps   = 1'b0;
        sink_style = 0;
        hold_req   = 250;
        repeat (48) send_voxel(random_voxel());
        drain_results();
        src_gaps = 1'b1;
    endtask

    task automatic test_random_stream();
        logic [5:0][23:0] colors;
        t_mode            mode;
        for (int p = 0; p < RandomPhases; p++) begin
            for (int i = 0; i < 6; i++)
                colors[i] = random_rgb();
            mode = (p < 4) ? t_mode'(p) : t_mode'($urandom_range(0, 3));
            load_config(colors, mode);
            src_gaps     = (p != 2);
            burst_left   = 0;
            sink_style   = p % 3;
            sink_pattern = 16'($urandom) | 16'h8001;
            repeat (RandomItems / RandomPhases) send_voxel(random_voxel());
        end
    endtask

    // receiver: long hold-off on request, otherwise its own stall pattern
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (sink_style)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    out_ch.ready <= sink_pattern[0];
                    sink_pattern = {sink_pattern[0], sink_pattern[15:1]};
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_shade exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (shade_expect.size() == 0) begin
                $display("%0t: unexpected transaction status=%0d rgba=%h%h%h%h face=%0d",
                         $time, out_ch.status, out_ch.out_red, out_ch.out_green,
                         out_ch.out_blue, out_ch.out_alpha, out_ch.chosen_face);
                errors++;
            end else begin
                exp_res = shade_expect.pop_front();
                if (out_ch.status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, out_ch.status);
                    errors++;
                end
                if (out_ch.out_red !== exp_res.red) begin
                    $display("%0t: out_red expected %0d actual %0d",
                             $time, exp_res.red, out_ch.out_red);
                    errors++;
                end
                if (out_ch.out_green !== exp_res.green) begin
                    $display("%0t: out_green expected %0d actual %0d",
                             $time, exp_res.green, out_ch.out_green);
                    errors++;
                end
                if (out_ch.out_blue !== exp_res.blue) begin
                    $display("%0t: out_blue expected %0d actual %0d",
                             $time, exp_res.blue, out_ch.out_blue);
                    errors++;
                end
                if (out_ch.out_alpha !== exp_res.alpha) begin
                    $display("%0t: out_alpha expected %0d actual %0d",
                             $time, exp_res.alpha, out_ch.out_alpha);
                    errors++;
                end
                if (out_ch.chosen_face !== exp_res.face) begin
                    $display("%0t: chosen_face expected %0d actual %0d",
                             $time, exp_res.face, out_ch.chosen_face);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("voxel_face_shade_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.voxel_present = 1'b0;
        in_ch.base_red      = '0;
        in_ch.base_green    = '0;
        in_ch.base_blue     = '0;
        in_ch.base_alpha    = '0;
        in_ch.exposed_faces = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        errors              = 0;
        cycle_cnt           = 0;
        src_gaps            = 1'b1;
        burst_left          = 0;
        sink_style          = 1;
        sink_pattern        = 16'hB5E3;
        hold_req            = 0;
        hold_left           = 0;
        face_rgb            = '{24'hFFFF00, 24'h0000FF, 24'h00FFFF,
                                24'hFF0000, 24'hFF00FF, 24'h00FF00};
        shade_mode          = MODE_REPLACE;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_face_select();
        test_config_extremes();
        test_red_material();
        test_backpressure();
        test_random_stream();
        drain_results();

        if (errors == 0)
            $display("voxel_face_shade_tb passed");
        else
            $display("voxel_face_shade_tb failed");
        $finish;
    end

endmodule
